/* hw/rtl/dpb_pkg.sv */
package dpb_pkg;

  // Subsampling step of the pixel grid and the number of coordinate bits kept
  localparam int SubsampleStep = 3;
  localparam int CoordBits     = 12;

  localparam int PixW   = 12;
  localparam int DepthW = 16;
  localparam int ColW   = 8;
  localparam int CtrW   = 16;
  localparam int RecipW = 24;
  localparam int PointW = 20;
  localparam int CfgW   = 24;
  localparam int CfgIdxW = 3;

  // Width of |d| * Z and of |d| * Z * recip
  localparam int Prod1W = CtrW + DepthW;
  localparam int Prod2W = Prod1W + RecipW;
  // Q.40 -> Q.12 rounding
  localparam int RndShift = 28;
  localparam int QuotW    = Prod2W + 1 - RndShift;

  localparam logic [PointW-1:0] SatPos = PointW'((1 << (PointW - 1)) - 1);
  localparam logic [PointW-1:0] SatNeg = PointW'(1 << (PointW - 1));

  localparam logic [PixW-1:0] CoordMask = PixW'((1 << CoordBits) - 1);

  // Divisibility by the step: multiply by a rounded-up reciprocal
  localparam int DivShift = PixW + 5;
  localparam int DivMul   = ((1 << DivShift) + SubsampleStep - 1) / SubsampleStep;
  localparam int DivMulW  = PixW + DivShift + 2;

  // Register indices
  localparam logic [CfgIdxW-1:0] CfgCenterX    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCenterY    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRecipFocX  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRecipFocY  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDepthMin   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDepthMax   = 3'd5;

  typedef struct packed {
    logic [PixW-1:0]   pixel_col;
    logic [PixW-1:0]   pixel_row;
    logic [DepthW-1:0] depth_value;
    logic [ColW-1:0]   blue_in;
    logic [ColW-1:0]   green_in;
    logic [ColW-1:0]   red_in;
  } dpb_in_t;

  typedef struct packed {
    logic signed [PointW-1:0] point_x;
    logic signed [PointW-1:0] point_y;
    logic [DepthW-1:0]        point_z;
    logic [ColW-1:0]          blue_out;
    logic [ColW-1:0]          green_out;
    logic [ColW-1:0]          red_out;
  } dpb_out_t;

  // Load enables of the multiply stages, shared by both axes
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } dpb_en_t;

  function automatic logic is_multiple(input logic [PixW-1:0] coord);
    logic [DivMulW-1:0] prod;
    logic [PixW-1:0]    quot;
    logic [PixW-1:0]    back;
    prod = DivMulW'(coord) * DivMulW'(DivMul);
    quot = PixW'(prod >> DivShift);
    back = PixW'(quot * SubsampleStep);
    return back == coord;
  endfunction

endpackage

/* hw/rtl/depth_pixel_backprojection.sv */
// Throughput: one pixel per cycle while the output is ready (out_ready_i high).
// A stalled output fills the four stages with no loss of pixels.
// Stages: screen and offset, |d|*Z, *recip, round and saturate into the output reg.
// Reset (rst_ni low, asynchronous): pipeline emptied, config regs take defaults.
// Skipped pixels are dropped in the first stage and give no output transaction.
module depth_pixel_backprojection import dpb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dpb_in_t             in_data_i,
  // point output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dpb_out_t            out_data_o,
  // register writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  typedef struct packed {
    logic [DepthW-1:0] z;
    logic [ColW-1:0]   blue;
    logic [ColW-1:0]   green;
    logic [ColW-1:0]   red;
  } side_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CtrW-1:0]   center_x_q, center_y_q;
  logic [RecipW-1:0] recip_x_q, recip_y_q;
  logic [DepthW-1:0] depth_min_q, depth_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= CtrW'(5112);
      center_y_q  <= CtrW'(3832);
      recip_x_q   <= RecipW'(31957);
      recip_y_q   <= RecipW'(31957);
      depth_min_q <= DepthW'(41);
      depth_max_q <= DepthW'(20480);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCenterX:   center_x_q  <= cfg_data_i[CtrW-1:0];
        CfgCenterY:   center_y_q  <= cfg_data_i[CtrW-1:0];
        CfgRecipFocX: recip_x_q   <= cfg_data_i[RecipW-1:0];
        CfgRecipFocY: recip_y_q   <= cfg_data_i[RecipW-1:0];
        CfgDepthMin:  depth_min_q <= cfg_data_i[DepthW-1:0];
        CfgDepthMax:  depth_max_q <= cfg_data_i[DepthW-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its content moves on.
  // ---------------------------------------------------------------------------
  logic    v1_q, v2_q, v3_q, v4_q;
  logic    en1, en2, en3, en4;
  dpb_en_t en_mul;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign en_mul = '{s2: en2, s3: en3, s4: en4};
  assign in_ready_o = en1;

  // ---------------------------------------------------------------------------
  // Stage 1: subsample and depth window, signed offsets from the principal point
  // ---------------------------------------------------------------------------
  logic [PixW-1:0] col, row;
  logic [CtrW-1:0] scaled_x, scaled_y;
  logic            keep, neg_x, neg_y;
  logic [CtrW-1:0] mag_x_d, mag_y_d;

  assign col = in_data_i.pixel_col & CoordMask;
  assign row = in_data_i.pixel_row & CoordMask;

  // coordinates become Q12.4 to line up with the principal point
  assign scaled_x = {col, 4'b0};
  assign scaled_y = {row, 4'b0};
  assign neg_x    = scaled_x < center_x_q;
  assign neg_y    = scaled_y < center_y_q;
  assign mag_x_d  = neg_x ? (center_x_q - scaled_x) : (scaled_x - center_x_q);
  assign mag_y_d  = neg_y ? (center_y_q - scaled_y) : (scaled_y - center_y_q);

  assign keep = is_multiple(col) && is_multiple(row)
             && (in_data_i.depth_value >= depth_min_q)
             && (in_data_i.depth_value <= depth_max_q);

  logic [CtrW-1:0] mag_x_q, mag_y_q;
  logic            neg_x_q, neg_y_q;
  side_t           side1_q, side2_q, side3_q, side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i && keep;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mag_x_q <= mag_x_d;
      mag_y_q <= mag_y_d;
      neg_x_q <= neg_x;
      neg_y_q <= neg_y;
      side1_q <= '{z:     in_data_i.depth_value,
                   blue:  in_data_i.blue_in,
                   green: in_data_i.green_in,
                   red:   in_data_i.red_in};
    end
    if (en2) side2_q <= side1_q;
    if (en3) side3_q <= side2_q;
    if (en4) side4_q <= side3_q;
  end

  // ---------------------------------------------------------------------------
  // Stages 2-4: one multiply chain per axis
  // ---------------------------------------------------------------------------
  logic signed [PointW-1:0] point_x, point_y;

  dpb_axis u_axis_x (
    .clk_i   (clk_i),
    .en_i    (en_mul),
    .mag_i   (mag_x_q),
    .neg_i   (neg_x_q),
    .depth_i (side1_q.z),
    .recip_i (recip_x_q),
    .coord_o (point_x)
  );

  dpb_axis u_axis_y (
    .clk_i   (clk_i),
    .en_i    (en_mul),
    .mag_i   (mag_y_q),
    .neg_i   (neg_y_q),
    .depth_i (side1_q.z),
    .recip_i (recip_y_q),
    .coord_o (point_y)
  );

  assign out_valid_o = v4_q;
  assign out_data_o  = '{point_x:   point_x,
                         point_y:   point_y,
                         point_z:   side4_q.z,
                         blue_out:  side4_q.blue,
                         green_out: side4_q.green,
                         red_out:   side4_q.red};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a screened-out pixel never enters the pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !keep) |=> !v1_q)
    else $error("dropped pixel entered stage 1");

  // backpressure only once every stage holds a point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q && !out_ready_i))
    else $error("input stalled with a free stage");

  // a held first stage keeps its content
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en2) |=> (v1_q && $stable(side1_q) && $stable(mag_x_q) && $stable(mag_y_q)))
    else $error("stage 1 lost or changed a point under stall");

  // a taken point is replaced only by what stage 3 held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && out_ready_i && !v3_q) |=> !v4_q)
    else $error("output repeated a point");

endmodule

/* hw/rtl/dpb_axis.sv */
module dpb_axis import dpb_pkg::*; (
  input  logic                     clk_i,
  input  dpb_en_t                  en_i,
  input  logic [CtrW-1:0]          mag_i,
  input  logic                     neg_i,
  input  logic [DepthW-1:0]        depth_i,
  input  logic [RecipW-1:0]        recip_i,
  output logic signed [PointW-1:0] coord_o
);

  logic [Prod1W-1:0] p1_q, p1_d;
  logic [Prod2W-1:0] p2_q, p2_d;
  logic              neg2_q, neg3_q;
  logic [PointW-1:0] coord_q, coord_d;
  logic [Prod2W:0]   rnd;
  logic [QuotW-1:0]  quot;
  logic [PointW-1:0] mag_sat;

  assign p1_d = Prod1W'(mag_i) * Prod1W'(depth_i);
  assign p2_d = Prod2W'(p1_q) * Prod2W'(recip_i);

  // round half away from zero on the magnitude, then saturate and sign
  always_comb begin
    rnd  = (Prod2W + 1)'(p2_q) + (Prod2W + 1)'(1 << (RndShift - 1));
    quot = rnd[Prod2W:RndShift];
    if (neg3_q) begin
      mag_sat = (quot > QuotW'(SatNeg)) ? SatNeg : PointW'(quot);
      coord_d = PointW'(0) - mag_sat;
    end else begin
      mag_sat = (quot > QuotW'(SatPos)) ? SatPos : PointW'(quot);
      coord_d = mag_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      p1_q   <= p1_d;
      neg2_q <= neg_i;
    end
    if (en_i.s3) begin
      p2_q   <= p2_d;
      neg3_q <= neg2_q;
    end
    if (en_i.s4) begin
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

/* bench/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dpb_pkg::*;

  // Clock, reset and run length
  localparam int HalfPeriod  = 4;
  localparam int ResetCycles = 7;
  localparam int Latency     = 4;          // input transaction to point
  localparam int LongHold    = 120;        // receiver hold-off, fills the four stages
  localparam int unsigned CycleLimit = 500000;

  // Indices past the last register; writes to them must change nothing
  localparam logic [CfgIdxW-1:0] CfgSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpare7 = 3'd7;

  // Independent model of the backprojection: own copy of the registers, queue of
  // points still owed by the block, mismatch bookkeeping.
  class point_tracker;
    localparam int MaxReports = 20;

    logic [CtrW-1:0]   centre_col, centre_row;
    logic [RecipW-1:0] recip_col, recip_row;
    logic [DepthW-1:0] depth_lo, depth_hi;
    dpb_out_t          points_due[$];
    int unsigned       n_pixels, n_screened, n_points, n_clipped, n_mismatch;

    function new();
      centre_col = 16'd5112;
      centre_row = 16'd3832;
      recip_col  = 24'd31957;
      recip_row  = 24'd31957;
      depth_lo   = 16'd41;
      depth_hi   = 16'd20480;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
      case (idx)
        CfgCenterX:   centre_col = value[CtrW-1:0];
        CfgCenterY:   centre_row = value[CtrW-1:0];
        CfgRecipFocX: recip_col  = value[RecipW-1:0];
        CfgRecipFocY: recip_row  = value[RecipW-1:0];
        CfgDepthMin:  depth_lo   = value[DepthW-1:0];
        CfgDepthMax:  depth_hi   = value[DepthW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return points_due.size();
    endfunction

    // (coord*16 - centre) * z * recip, Q.40 rounded half away to Q.12, clipped
    function logic [PointW-1:0] backproject(logic [PixW-1:0] coord, logic [CtrW-1:0] centre,
                                            logic [DepthW-1:0] z, logic [RecipW-1:0] recip);
      logic [CtrW-1:0] scaled, offset;
      logic            neg;
      logic [63:0]     prod, q;
      scaled = {coord, 4'b0000};
      neg    = scaled < centre;
      offset = neg ? centre - scaled : scaled - centre;
      prod   = 64'(offset) * 64'(z) * 64'(recip);
      q      = (prod + (64'd1 << (RndShift - 1))) >> RndShift;
      if (neg && q > 64'(SatNeg)) begin
        q = 64'(SatNeg);
        n_clipped++;
      end else if (!neg && q > 64'(SatPos)) begin
        q = 64'(SatPos);
        n_clipped++;
      end
      return neg ? PointW'(64'd0 - q) : PointW'(q);
    endfunction

    function void note_pixel(dpb_in_t px);
      logic [PixW-1:0] col, row;
      dpb_out_t        pt;
      col = px.pixel_col & CoordMask;
      row = px.pixel_row & CoordMask;
      n_pixels++;
      if ((col % SubsampleStep) != 0 || (row % SubsampleStep) != 0 ||
          px.depth_value < depth_lo || px.depth_value > depth_hi) begin
        n_screened++;
        return;
      end
      pt.point_x   = backproject(col, centre_col, px.depth_value, recip_col);
      pt.point_y   = backproject(row, centre_row, px.depth_value, recip_row);
      pt.point_z   = px.depth_value;
      pt.blue_out  = px.blue_in;
      pt.green_out = px.green_in;
      pt.red_out   = px.red_in;
      points_due = {points_due, pt};
    endfunction

    task report(string msg);
      n_mismatch++;
      if (n_mismatch <= MaxReports)
        $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    task compare_field(string field, logic [CfgW-1:0] got, logic [CfgW-1:0] want);
      if (got !== want)
        report($sformatf("point %0d %s: got %0h, want %0h", n_points, field, got, want));
    endtask

    task check_point(dpb_out_t got);
      dpb_out_t want;
      if (points_due.size() == 0) begin
        report($sformatf("point x=%0h y=%0h z=%0h with no pixel waiting",
                         got.point_x, got.point_y, got.point_z));
        return;
      end
      want = points_due.pop_front();
      n_points++;
      compare_field("point_x", CfgW'(got.point_x), CfgW'(want.point_x));
      compare_field("point_y", CfgW'(got.point_y), CfgW'(want.point_y));
      compare_field("point_z", CfgW'(got.point_z), CfgW'(want.point_z));
      compare_field("blue_out", CfgW'(got.blue_out), CfgW'(want.blue_out));
      compare_field("green_out", CfgW'(got.green_out), CfgW'(want.green_out));
      compare_field("red_out", CfgW'(got.red_out), CfgW'(want.red_out));
    endtask
  endclass

  // Every input known from time zero
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  dpb_in_t            in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  dpb_out_t           out_data;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = '0;
  logic [CfgW-1:0]    cfg_data  = '0;

  point_tracker sb;
  bit           idle_on      = 1'b1;  // random gaps on both sides while set
  bit           hold_request = 1'b0;  // asks the receiver for one long hold-off
  int unsigned  n_settings   = 0;
  int unsigned  cycles       = 0;

  depth_pixel_backprojection u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #HalfPeriod clk = 1'b1;
    #HalfPeriod clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d points outstanding", cycles, sb.pending());
      $display("** depth_pixel_backprojection: FAILED **");
      $finish;
    end
  end

  // Both handshakes are sampled at the edge, before any NBA of this step lands.
  // A pixel accepted here cannot leave in the same cycle, so order is immaterial.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_pixel(in_data);
      if (out_valid && out_ready)
        sb.check_point(out_data);
    end
  end

  // Receiver: ready by default, random stall bursts while idle_on is set,
  // and one long hold-off on request so the pipe backs up onto in_ready.
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // All driving tasks are entered and left at a rising edge.
  task automatic send_pixel(input dpb_in_t px);
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_fixed(input int unsigned col, input int unsigned row,
                            input int unsigned depth, input int unsigned b,
                            input int unsigned g, input int unsigned r);
    dpb_in_t px;
    px.pixel_col   = PixW'(col);
    px.pixel_row   = PixW'(row);
    px.depth_value = DepthW'(depth);
    px.blue_in     = ColW'(b);
    px.green_in    = ColW'(g);
    px.red_in      = ColW'(r);
    send_pixel(px);
  endtask

  task automatic idle_input(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sender stops and waits for every owed point, then lets the pipe settle
  // (screened pixels leave no trace on the output).
  task automatic drain_points();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CfgW-1:0] cx, input logic [CfgW-1:0] cy,
                           input logic [CfgW-1:0] rx, input logic [CfgW-1:0] ry,
                           input logic [CfgW-1:0] dlo, input logic [CfgW-1:0] dhi);
    write_reg(CfgCenterX, cx);
    write_reg(CfgCenterY, cy);
    write_reg(CfgRecipFocX, rx);
    write_reg(CfgRecipFocY, ry);
    write_reg(CfgDepthMin, dlo);
    write_reg(CfgDepthMax, dhi);
    n_settings++;
  endtask

  task automatic configure_random(input bit wide_recip);
    logic [DepthW-1:0] lo, hi;
    lo = DepthW'($urandom_range(0, 40000));
    hi = DepthW'($urandom_range(lo, 65535));
    configure(CfgW'($urandom_range(0, 65535)), CfgW'($urandom_range(0, 65535)),
              wide_recip ? CfgW'($urandom) : CfgW'($urandom_range(1, 24'h00FFFF)),
              wide_recip ? CfgW'($urandom) : CfgW'($urandom_range(1, 24'h00FFFF)),
              CfgW'(lo), CfgW'(hi));
  endtask

  // Mostly pixels that land on the grid with an accepted depth, so points flow;
  // the rest sit on the depth limits, just outside them, have random coordinates, or are pure noise.
  function automatic dpb_in_t random_pixel();
    dpb_in_t     px;
    int unsigned kind, lo, hi;
    lo   = sb.depth_lo;
    hi   = sb.depth_hi;
    kind = $urandom_range(0, 9);
    px.pixel_col   = PixW'(SubsampleStep * $urandom_range(0, 4095 / SubsampleStep));
    px.pixel_row   = PixW'(SubsampleStep * $urandom_range(0, 4095 / SubsampleStep));
    px.depth_value = (lo <= hi) ? DepthW'($urandom_range(lo, hi)) : DepthW'($urandom);
    px.blue_in     = ColW'($urandom);
    px.green_in    = ColW'($urandom);
    px.red_in      = ColW'($urandom);
    case (kind)
      0: px.depth_value = $urandom_range(0, 1) ? DepthW'(lo) : DepthW'(hi);
      7: begin
        px.pixel_col = PixW'($urandom);
        px.pixel_row = PixW'($urandom);
      end
      8: px.depth_value = $urandom_range(0, 1) ? DepthW'(lo - 1) : DepthW'(hi + 1);
      9: px = {$urandom, $urandom};
      default: ;
    endcase
    return px;
  endfunction

  // One stretch of random traffic. Idling is re-drawn every 60 transactions so
  // quiet stretches alternate with busy ones; halfway the sender pauses for a
  // full drain.
  task automatic stream_pixels(input int unsigned count, input bit with_idle,
                               input bit long_hold);
    int unsigned i;
    if (long_hold)
      hold_request = 1'b1;
    for (i = 0; i < count; i++) begin
      if (i % 60 == 0)
        idle_on = with_idle && ($urandom_range(0, 3) != 0);
      if (i == count / 2)
        drain_points();
      if (idle_on && $urandom_range(0, 5) == 0)
        idle_input($urandom_range(1, 12));
      send_pixel(random_pixel());
    end
    drain_points();
  endtask

  initial begin
    sb = new();
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed set on the reset registers: principal point at 319.5, 239.5
    send_fixed(0, 0, 41, 0, 0, 0);                  // corner, depth on the lower limit
    send_fixed(4095, 4095, 20480, 255, 255, 255);   // far corner, depth on the upper limit
    send_fixed(318, 240, 40, 1, 2, 3);              // just under the lower limit
    send_fixed(321, 237, 20481, 4, 5, 6);           // just over the upper limit
    send_fixed(318, 237, 4096, 8'h12, 8'h34, 8'h56);// left of and above the centre
    send_fixed(321, 240, 4096, 8'hAA, 8'h55, 8'hF0);// right of and below the centre
    send_fixed(1, 0, 4096, 9, 9, 9);                // column off the grid
    send_fixed(0, 2, 4096, 9, 9, 9);                // row off the grid
    send_fixed(3, 3, 0, 7, 7, 7);                   // zero depth
    send_fixed(3, 6, 65535, 7, 7, 7);               // full-scale depth
    send_fixed(4095, 0, 20480, 8'h80, 8'h01, 8'hFE);
    send_fixed(0, 4095, 20480, 8'h01, 8'hFE, 8'h80);
    send_fixed(2046, 1023, 12345, 8'hA5, 8'h5A, 8'h3C);
    send_fixed(4094, 4093, 12345, 8'h0F, 8'hF0, 8'hFF);
    drain_points();
    stream_pixels(250, 1'b1, 1'b0);

    // Camera with principal point at 639.5, 479.5, full depth range; the receiver backs up once
    configure(24'd10232, 24'd7672, 24'd27962, 24'd27962, 24'd0, 24'hFFFF);
    stream_pixels(300, 1'b1, 1'b1);

    // Extremes: centre on opposite corners and full-scale reciprocals, so the x axis
    // clips negative and the y axis clips positive
    configure(24'hFFFF, 24'h0000, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'hFFFF);
    send_fixed(0, 4095, 65535, 1, 2, 3);
    send_fixed(4095, 0, 65535, 4, 5, 6);
    send_fixed(4095, 4095, 1, 7, 8, 9);
    drain_points();
    stream_pixels(250, 1'b1, 1'b0);

    // Inverted depth limits: nothing may come out. The upper bits of the
    // written data must be dropped, and the spare indices must be ignored.
    configure(24'hFF0000, 24'hAB0000, 24'd0, 24'd1, 24'h12FFFF, 24'h340000);
    write_reg(CfgSpare6, 24'hFFFFFF);
    write_reg(CfgSpare7, 24'h000001);
    stream_pixels(150, 1'b1, 1'b0);

    // A single accepted depth
    begin
      logic [DepthW-1:0] only_depth;
      only_depth = DepthW'($urandom_range(1, 65534));
      configure(CfgW'($urandom_range(0, 65535)), CfgW'($urandom_range(0, 65535)),
                CfgW'($urandom_range(1, 4095)), CfgW'($urandom_range(1, 4095)),
                CfgW'(only_depth), CfgW'(only_depth));
    end
    stream_pixels(200, 1'b1, 1'b0);

    configure_random(1'b1);
    stream_pixels(200, 1'b1, 1'b0);
    configure_random(1'b0);
    stream_pixels(200, 1'b1, 1'b0);

    // Last part at full rate on both sides
    idle_on = 1'b0;
    configure_random(1'b0);
    stream_pixels(200, 1'b0, 1'b0);

    $display("covered %0d pixels (%0d screened out), %0d points checked, %0d clipped axes",
             sb.n_pixels, sb.n_screened, sb.n_points, sb.n_clipped);
    $display("over %0d register settings, %0d mismatches", n_settings + 1, sb.n_mismatch);
    if (sb.n_mismatch == 0)
      $display("** depth_pixel_backprojection: PASSED **");
    else
      $display("** depth_pixel_backprojection: FAILED **");
    $finish;
  end

endmodule
